// ----- sv/record_channel_sample_extractor_assert.svh -----
// Assertion macros used by the block's top-level RTL.
`ifndef RECORD_CHANNEL_SAMPLE_EXTRACTOR_ASSERT_SVH
`define RECORD_CHANNEL_SAMPLE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RCSE_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCSE_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rcse_pkg.sv -----
`default_nettype none
package rcse_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned PosBits    = 18;
  localparam int unsigned RawBits    = 2 * ByteBits;
  localparam int unsigned ValueBits  = 48;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  typedef enum logic [CfgIdxBits-1:0] {
    REG_LEAD_BYTES      = 3'd0,
    REG_CHANNEL_SAMPLES = 3'd1,
    REG_TRAIL_BYTES     = 3'd2,
    REG_GAIN            = 3'd3,
    REG_BIAS            = 3'd4,
    REG_FIRST_SAMPLE    = 3'd5,
    REG_SAMPLE_COUNT    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        lead_bytes;
    logic [14:0]        channel_samples;
    logic [15:0]        trail_bytes;
    logic signed [31:0] gain;
    logic signed [31:0] bias;
    logic [30:0]        first_sample;
    logic [30:0]        sample_count;
  } cfg_t;

  // One kept sample on its way from the front to the back.
  typedef struct packed {
    logic signed [RawBits-1:0] raw;
    logic                      last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic push;
    logic finished;
  } front_status_t;

endpackage
`default_nettype wire

// ----- sv/rcse_if.sv -----
`default_nettype none
interface rcse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rcse_value_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] physical_value;
  logic               last;
  modport source (output valid, output physical_value, output last, input ready);
  modport sink (input valid, input physical_value, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/rcse_front.sv -----
`default_nettype none
module rcse_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rcse_pkg::cfg_t         cfg,
  input  wire logic                   in_valid,
  input  wire logic [7:0]             in_byte,
  output logic                        in_ready,
  input  wire logic                   queue_full,
  output rcse_pkg::entry_t            entry,
  output rcse_pkg::front_status_t     status
);
  import rcse_pkg::*;

  logic [PosBits-1:0] record_position;
  logic [ByteBits-1:0] low_byte_hold;
  logic [31:0]        sample_index;
  logic [30:0]        emitted_count;
  logic               finished;

  logic [PosBits-1:0] data_end;
  logic [PosBits-1:0] total;
  logic [PosBits-1:0] pos_inc;
  logic               in_data;
  logic               high_byte;
  logic               keep;
  logic               accept;
  logic [30:0]        emitted_inc;

  assign data_end  = PosBits'(cfg.lead_bytes) + {2'b0, cfg.channel_samples, 1'b0};
  assign total     = data_end + PosBits'(cfg.trail_bytes);
  assign pos_inc   = record_position + 1'b1;
  assign in_data   = (record_position >= PosBits'(cfg.lead_bytes)) &&
                     (record_position < data_end);
  assign high_byte = record_position[0] ^ cfg.lead_bytes[0];
  assign keep      = in_data && high_byte && !finished &&
                     (sample_index >= {1'b0, cfg.first_sample}) &&
                     (emitted_count < cfg.sample_count);
  assign emitted_inc = emitted_count + 1'b1;

  assign in_ready   = !queue_full;
  assign accept     = in_valid && in_ready;
  assign entry.raw  = {in_byte, low_byte_hold};
  assign entry.last = (emitted_inc == cfg.sample_count);
  assign status.push     = accept && keep;
  assign status.finished = finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_position <= '0;
      low_byte_hold   <= '0;
      sample_index    <= '0;
      emitted_count   <= '0;
      finished        <= 1'b0;
    end else if (accept && !finished) begin
      if (in_data) begin
        if (!high_byte) begin
          low_byte_hold <= in_byte;
        end else begin
          if (keep) begin
            emitted_count <= emitted_inc;
            if (emitted_inc == cfg.sample_count) begin
              finished <= 1'b1;
            end
          end
          // hold at the top rather than wrap
          if (sample_index != '1) begin
            sample_index <= sample_index + 1'b1;
          end
        end
      end
      // a position at or past a shortened record wraps to the start
      if ({1'b0, pos_inc} >= {1'b0, total} || pos_inc == '0) begin
        record_position <= '0;
      end else begin
        record_position <= pos_inc;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/rcse_queue.sv -----
`default_nettype none
module rcse_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rcse_pkg::entry_t    push_entry,
  input  wire logic                pop,
  output rcse_pkg::entry_t         head,
  output rcse_pkg::queue_status_t  status
);
  import rcse_pkg::*;

  entry_t                  slots [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr;
  logic [QueuePtrBits-1:0] rd_ptr;
  logic [QueuePtrBits:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign status.full  = (count == (QueuePtrBits+1)'(QueueDepth));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/rcse_back.sv -----
`default_nettype none
module rcse_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rcse_pkg::cfg_t     cfg,
  input  wire logic               head_valid,
  input  wire rcse_pkg::entry_t   head,
  output logic                    pop,
  rcse_value_if.source            value_out
);
  import rcse_pkg::*;

  localparam logic signed [ValueBits-1:0] ValueMax = {1'b0, {(ValueBits-1){1'b1}}};
  localparam logic signed [ValueBits-1:0] ValueMin = {1'b1, {(ValueBits-1){1'b0}}};

  logic                        s1_valid;
  logic signed [ValueBits-1:0] s1_product;
  logic                        s1_last;
  logic                        s2_valid;
  logic signed [ValueBits-1:0] s2_value;
  logic                        s2_last;

  logic                        s2_take;
  logic                        s1_take;
  logic signed [ValueBits:0]   sum;
  logic signed [ValueBits-1:0] clamped;

  assign s2_take = !s2_valid || value_out.ready;
  assign s1_take = !s1_valid || s2_take;
  assign pop     = head_valid && s1_take;

  assign sum = {s1_product[ValueBits-1], s1_product} + (ValueBits+1)'(cfg.bias);

  always_comb begin
    if (!sum[ValueBits] && sum[ValueBits-1]) begin
      clamped = ValueMax;
    end else if (sum[ValueBits] && !sum[ValueBits-1]) begin
      clamped = ValueMin;
    end else begin
      clamped = sum[ValueBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= head_valid;
      end
      if (s2_take) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_product <= ValueBits'(cfg.gain * head.raw);
      s1_last    <= head.last;
    end
    if (s2_take && s1_valid) begin
      s2_value <= clamped;
      s2_last  <= s1_last;
    end
  end

  assign value_out.valid          = s2_valid;
  assign value_out.physical_value = s2_value;
  assign value_out.last           = s2_last;
endmodule
`default_nettype wire

// ----- sv/record_channel_sample_extractor.sv -----
// Channel   Dir  Payload                          Handshake
// byte_in   in   data_byte [7:0]                  valid/ready
// value_out out  physical_value [47:0] s, last    valid/ready
// cfg       in   cfg_index [2:0], cfg_data [31:0] cfg_write, no wait
//
// One byte per cycle is taken while the four-entry sample queue has room.
// A kept sample passes from its high byte to value_out through the queue,
// the 32x16 multiply register, then bias add and clamp into the output register.
// A stall on value_out backs up the multiply stages and then the queue;
// byte_in drops ready only when the queue is full. Synchronous reset clears
// the stream position and counters and loads the register defaults.
`default_nettype none
`include "record_channel_sample_extractor_assert.svh"
module record_channel_sample_extractor (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [rcse_pkg::CfgIdxBits-1:0]   cfg_index,
  input  wire logic [rcse_pkg::CfgBits-1:0]      cfg_data,
  rcse_byte_if.sink                              byte_in,
  rcse_value_if.source                           value_out
);
  import rcse_pkg::*;

  cfg_t          cfg;
  entry_t        front_entry;
  entry_t        head;
  queue_status_t q_stat;
  front_status_t f_stat;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lead_bytes      <= '0;
      cfg.channel_samples <= 15'd1;
      cfg.trail_bytes     <= '0;
      cfg.gain            <= 32'sd65536;
      cfg.bias            <= '0;
      cfg.first_sample    <= '0;
      cfg.sample_count    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEAD_BYTES:      cfg.lead_bytes      <= cfg_data[15:0];
        REG_CHANNEL_SAMPLES: cfg.channel_samples <= cfg_data[14:0];
        REG_TRAIL_BYTES:     cfg.trail_bytes     <= cfg_data[15:0];
        REG_GAIN:            cfg.gain            <= cfg_data;
        REG_BIAS:            cfg.bias            <= cfg_data;
        REG_FIRST_SAMPLE:    cfg.first_sample    <= cfg_data[30:0];
        REG_SAMPLE_COUNT:    cfg.sample_count    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rcse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (byte_in.valid),
    .in_byte    (byte_in.data_byte),
    .in_ready   (byte_in.ready),
    .queue_full (q_stat.full),
    .entry      (front_entry),
    .status     (f_stat)
  );

  rcse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_stat.push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_stat)
  );

  rcse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (!q_stat.empty),
    .head       (head),
    .pop        (pop),
    .value_out  (value_out)
  );

  `RCSE_ASSERT_IMP(a_full_stalls_input, clk, rst, q_stat.full, !byte_in.ready, "input taken while queue full")
  `RCSE_ASSERT_IMP(a_no_push_after_end, clk, rst, f_stat.finished, !f_stat.push, "sample queued after final transaction")
  `RCSE_ASSERT_NXT(a_idle_after_last, clk, rst, value_out.valid && value_out.ready && value_out.last, !value_out.valid, "output after final transaction")
endmodule
`default_nettype wire

// ----- verif/tb_record_channel_sample_extractor.sv -----
`timescale 1ns / 100ps
module tb_record_channel_sample_extractor;
  import rcse_pkg::*;

  localparam int CycleLimit  = 100000;
  localparam int DrainCycles = 16;
  localparam int Segments    = 12;
  localparam int SegmentLen  = 50;
  localparam int PhaseOneEnd = 220;
  localparam int PhaseTwoEnd = 440;
  localparam longint ValueMax = (longint'(1) <<< 47) - 1;
  localparam longint ValueMin = -(longint'(1) <<< 47);

  typedef struct packed {
    logic signed [ValueBits-1:0] physical_value;
    logic                        last;
  } sample_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    cfg_reg_t                    reg_sel;
    logic [CfgBits-1:0]          data;
    logic                        typed;
    logic signed [ValueBits-1:0] phys;
    logic                        fin;
  } script_row_t;

  localparam int DirectedLen = 48;
  localparam script_row_t DirectedRows [DirectedLen] = '{
    // sample_count is 0 after reset: nothing comes out
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h34,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h12,        1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_SAMPLE_COUNT,    32'h7FFF_FFFF, 1'b0, 48'sd0, 1'b0},
    // reset gain is unity in Q16.16
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hFF,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h7F,        1'b1, 48'sd2147418112, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h00,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h80,        1'b1, -48'sd2147483648, 1'b0},
    // low byte with its top bit set must not sign-extend
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h80,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h00,        1'b1, 48'sd8388608, 1'b0},
    '{ROW_WRITE, REG_GAIN,            32'h8000_0000, 1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_BIAS,            32'h7FFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h00,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h80,        1'b1, 48'sd70370891661311, 1'b0},
    '{ROW_WRITE, REG_GAIN,            32'h7FFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_BIAS,            32'h8000_0000, 1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_LEAD_BYTES,      32'd1,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_CHANNEL_SAMPLES, 32'd2,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_TRAIL_BYTES,     32'd1,         1'b0, 48'sd0, 1'b0},
    // drop the first sample of this record, keep the second
    '{ROW_WRITE, REG_FIRST_SAMPLE,    32'd6,         1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h5A,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h3C,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hE1,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hFF,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h7F,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hC3,        1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_LEAD_BYTES,      32'hFFFF,      1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_CHANNEL_SAMPLES, 32'h7FFF,      1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_TRAIL_BYTES,     32'hFFFF,      1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h01,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hFE,        1'b0, 48'sd0, 1'b0},
    // empty record; the position is now past its end and wraps
    '{ROW_WRITE, REG_LEAD_BYTES,      32'd0,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_CHANNEL_SAMPLES, 32'd0,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_TRAIL_BYTES,     32'd0,         1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hAA,        1'b0, 48'sd0, 1'b0},
    // records with no samples of this channel
    '{ROW_WRITE, REG_LEAD_BYTES,      32'd2,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_TRAIL_BYTES,     32'd1,         1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h55,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h66,        1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_LEAD_BYTES,      32'd0,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_CHANNEL_SAMPLES, 32'd1,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_TRAIL_BYTES,     32'd0,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_FIRST_SAMPLE,    32'h7FFF_FFFF, 1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h0F,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'hF0,        1'b0, 48'sd0, 1'b0},
    // count already reached: emission stops with no last flag
    '{ROW_WRITE, REG_FIRST_SAMPLE,    32'd0,         1'b0, 48'sd0, 1'b0},
    '{ROW_WRITE, REG_SAMPLE_COUNT,    32'd2,         1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h11,        1'b0, 48'sd0, 1'b0},
    '{ROW_BYTE,  REG_LEAD_BYTES,      32'h22,        1'b0, 48'sd0, 1'b0}
  };

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [CfgBits-1:0] cfg_data;

  rcse_byte_if  byte_ch ();
  rcse_value_if value_ch ();

  record_channel_sample_extractor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_ch),
    .value_out (value_ch)
  );

  // Shadow of the block's registers and stream state
  cfg_t        shadow_cfg;
  int unsigned rec_pos;
  logic [7:0]  low_hold;
  int unsigned next_index;
  int unsigned n_emitted;
  bit          stream_done;

  sample_t pending_samples [$];
  sample_t typed_samples [int];
  int      bytes_sent;
  int      bytes_taken;
  int      mismatch_count;
  int      cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned gap_pct(input int n, input bit sink_side);
    if (n < PhaseOneEnd) return sink_side ? 78 : 24;
    if (n < PhaseTwoEnd) return sink_side ? 24 : 78;
    return 0;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  // Advance the shadow stream by one byte; report the sample it releases, if any.
  function automatic void extract_byte(input logic [7:0] b, output bit kept,
                                       output sample_t s);
    int unsigned data_end;
    int unsigned rec_len;
    logic signed [15:0] raw;
    longint scaled;
    kept = 1'b0;
    s = '0;
    if (stream_done) return;
    data_end = shadow_cfg.lead_bytes + 2 * shadow_cfg.channel_samples;
    rec_len  = data_end + shadow_cfg.trail_bytes;
    if (rec_pos >= shadow_cfg.lead_bytes && rec_pos < data_end) begin
      if (((rec_pos - shadow_cfg.lead_bytes) & 1) == 0) begin
        low_hold = b;
      end else begin
        raw = {b, low_hold};
        if (next_index >= shadow_cfg.first_sample && n_emitted < shadow_cfg.sample_count) begin
          scaled = longint'($signed(shadow_cfg.bias))
                 + longint'($signed(shadow_cfg.gain)) * longint'(raw);
          if (scaled > ValueMax) scaled = ValueMax;
          else if (scaled < ValueMin) scaled = ValueMin;
          n_emitted++;
          s.physical_value = scaled[ValueBits-1:0];
          s.last = (n_emitted == shadow_cfg.sample_count);
          stream_done = s.last;
          kept = 1'b1;
        end
        if (next_index != 32'hFFFF_FFFF) next_index++;
      end
    end
    rec_pos = (rec_pos + 1 >= rec_len) ? 0 : rec_pos + 1;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct(bytes_sent, 1'b0)) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold off the sender until every outstanding sample has arrived.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
    case (sel)
      REG_LEAD_BYTES:      shadow_cfg.lead_bytes = data[15:0];
      REG_CHANNEL_SAMPLES: shadow_cfg.channel_samples = data[14:0];
      REG_TRAIL_BYTES:     shadow_cfg.trail_bytes = data[15:0];
      REG_GAIN:            shadow_cfg.gain = data;
      REG_BIAS:            shadow_cfg.bias = data;
      REG_FIRST_SAMPLE:    shadow_cfg.first_sample = data[30:0];
      REG_SAMPLE_COUNT:    shadow_cfg.sample_count = data[30:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : track_stream
    sample_t predicted;
    sample_t want;
    bit kept;
    if (rst) begin
      value_ch.ready <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        extract_byte(byte_ch.data_byte, kept, predicted);
        if (typed_samples.exists(bytes_taken))
          pending_samples = {pending_samples, typed_samples[bytes_taken]};
        else if (kept)
          pending_samples = {pending_samples, predicted};
        bytes_taken++;
      end
      if (value_ch.valid && value_ch.ready) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected transaction: physical_value %0d, last %0b",
                 $signed(value_ch.physical_value), value_ch.last);
          mismatch_count++;
        end else begin
          want = pending_samples.pop_front();
          if (value_ch.physical_value !== want.physical_value) begin
            $error("physical_value: expected %0d, got %0d",
                   $signed(want.physical_value), $signed(value_ch.physical_value));
            mismatch_count++;
          end
          if (value_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, value_ch.last);
            mismatch_count++;
          end
        end
      end
      value_ch.ready <= ($urandom_range(99) >= gap_pct(bytes_taken, 1'b1));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb_record_channel_sample_extractor: errors");
      $finish;
    end
  end

  initial begin : run_stimulus
    logic [31:0] junk;
    int unsigned tail;
    shadow_cfg = '0;
    shadow_cfg.channel_samples = 15'd1;
    shadow_cfg.gain = 32'sd65536;
    rec_pos = 0;
    low_hold = '0;
    next_index = 0;
    n_emitted = 0;
    stream_done = 1'b0;
    bytes_sent = 0;
    bytes_taken = 0;
    mismatch_count = 0;
    cycles = 0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_LEAD_BYTES;
    cfg_data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DirectedLen; i++) begin
      if (DirectedRows[i].kind == ROW_WRITE) begin
        if (i > 0 && DirectedRows[i-1].kind == ROW_BYTE) settle();
        write_reg(DirectedRows[i].reg_sel, DirectedRows[i].data);
      end else begin
        if (DirectedRows[i].typed)
          typed_samples[bytes_sent] = {DirectedRows[i].phys, DirectedRows[i].fin};
        send_byte(DirectedRows[i].data[7:0]);
      end
    end

    // Random layouts and scales; the count is left open or already reached, so the stream never ends here
    for (int seg = 0; seg < Segments; seg++) begin
      settle();
      junk = $urandom;
      case ($urandom_range(9))
        0: write_reg(REG_LEAD_BYTES, junk);
        1, 2: write_reg(REG_LEAD_BYTES, {junk[31:16], 16'($urandom_range(5, 40))});
        default: write_reg(REG_LEAD_BYTES, {junk[31:16], 16'($urandom_range(0, 4))});
      endcase
      case ($urandom_range(19))
        0: write_reg(REG_CHANNEL_SAMPLES, {junk[31:15], 15'd0});
        1, 2: write_reg(REG_CHANNEL_SAMPLES, {junk[31:15], 15'h7FFF});
        3, 4: write_reg(REG_CHANNEL_SAMPLES, {junk[31:15], 15'($urandom_range(7, 300))});
        default: write_reg(REG_CHANNEL_SAMPLES, {junk[31:15], 15'($urandom_range(1, 6))});
      endcase
      junk = $urandom;
      case ($urandom_range(9))
        0: write_reg(REG_TRAIL_BYTES, junk);
        1, 2: write_reg(REG_TRAIL_BYTES, {junk[31:16], 16'($urandom_range(5, 40))});
        default: write_reg(REG_TRAIL_BYTES, {junk[31:16], 16'($urandom_range(0, 4))});
      endcase
      write_reg(REG_GAIN, pick_scale());
      write_reg(REG_BIAS, pick_scale());
      case ($urandom_range(9))
        0: write_reg(REG_FIRST_SAMPLE, {junk[31], 31'd0});
        1: write_reg(REG_FIRST_SAMPLE, {junk[31], 31'h7FFF_FFFF});
        default: write_reg(REG_FIRST_SAMPLE, next_index + $urandom_range(0, 3));
      endcase
      case ($urandom_range(9))
        0: write_reg(REG_SAMPLE_COUNT, n_emitted);
        1: write_reg(REG_SAMPLE_COUNT, {junk[31], 31'd0});
        default: write_reg(REG_SAMPLE_COUNT, {junk[31], 31'h7FFF_FFFF});
      endcase
      repeat (SegmentLen) send_byte(8'($urandom_range(255)));
    end

    // Close the stream with a last flag, then keep feeding bytes that must be dropped
    settle();
    tail = $urandom_range(3, 8);
    write_reg(REG_LEAD_BYTES, 32'd1);
    write_reg(REG_CHANNEL_SAMPLES, 32'd2);
    write_reg(REG_TRAIL_BYTES, 32'd1);
    write_reg(REG_GAIN, pick_scale());
    write_reg(REG_BIAS, pick_scale());
    write_reg(REG_FIRST_SAMPLE, next_index);
    write_reg(REG_SAMPLE_COUNT, n_emitted + tail);
    repeat (3 * tail + 26) send_byte(8'($urandom_range(255)));
    settle();

    if (mismatch_count == 0) begin
      $display("tb_record_channel_sample_extractor: clean");
    end else begin
      $display("tb_record_channel_sample_extractor: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/rcse_pkg.sv
sv/rcse_if.sv
sv/rcse_front.sv
sv/rcse_queue.sv
sv/rcse_back.sv
sv/record_channel_sample_extractor.sv
verif/tb_record_channel_sample_extractor.sv
